[hw/rtl/assert_macros.svh]
// Assertion macros used by the top level of the joystick report block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while arst_n is low.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk and switched off while arst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[hw/rtl/db9h_pkg.sv]
// Package of the joystick report block: beat types, register codes and the hat table.
`default_nettype none

package db9h_pkg;

	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] REG_MODE = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_CD32_PAD = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_MOVE_INTERVAL = 2'd2;

	localparam logic [1:0] MODE_GAME_PAD = 2'd0;
	localparam logic [1:0] MODE_AMIGA = 2'd1;
	localparam logic [1:0] MODE_PAD_MOUSE = 2'd2;
	localparam logic [1:0] MODE_ATARI = 2'd3;

	localparam logic KIND_GAME = 1'b0;
	localparam logic KIND_MOUSE = 1'b1;

	localparam logic [15:0] MOVE_INTERVAL_RESET = 16'd5000;
	localparam logic [7:0] STEP_PLUS = 8'd10;
	localparam logic [7:0] STEP_MINUS = 8'd246;

	localparam logic [3:0] HAT_CENTRED = 4'd8;
	localparam logic [3:0] HAT_TABLE [16] = '{
		4'd8, 4'd0, 4'd4, 4'd8, 4'd6, 4'd7, 4'd5, 4'd8,
		4'd2, 4'd1, 4'd3, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8
	};

	typedef struct packed {
		logic [15:0] pin_levels;
		logic [7:0]  pad_buttons;
		logic        link_configured;
		logic        report_accepted;
	} poll_t;

	typedef struct packed {
		logic              report_kind;
		logic [3:0]        hat_value;
		logic [7:0]        button_bits;
		logic signed [7:0] move_x;
		logic signed [7:0] move_y;
	} report_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic        cd32_pad;
		logic [15:0] move_interval;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  last_hat;
		logic [7:0]  last_pad_buttons;
		logic [7:0]  acc_x;
		logic [7:0]  acc_y;
		logic [2:0]  last_mouse_buttons;
		logic [3:0]  prev_dir_pins;
		logic [15:0] poll_count;
	} state_t;

endpackage

`default_nettype wire

[hw/rtl/db9h_core.sv]
// Combinational poll evaluation: next block state and the report of one poll.
`default_nettype none

module db9h_core (
	input  db9h_pkg::cfg_t    cfg,
	input  db9h_pkg::state_t  state,
	input  db9h_pkg::poll_t   poll,
	output db9h_pkg::state_t  state_next,
	output logic              emit,
	output db9h_pkg::report_t report
);

	logic [3:0] dir;
	logic [3:0] old;
	logic [2:0] fire;
	logic [3:0] hat;
	logic [7:0] game_btn;
	logic [7:0] ax;
	logic [7:0] ay;
	logic       tick;
	logic       ok;

	assign dir = poll.pin_levels[15:12];
	assign old = state.prev_dir_pins;
	assign fire = {poll.pin_levels[9], poll.pin_levels[10], poll.pin_levels[11]};
	assign hat = db9h_pkg::HAT_TABLE[dir];
	assign game_btn = cfg.cd32_pad ? poll.pad_buttons : {5'd0, fire};
	assign ok = poll.report_accepted;
	assign tick = (state.poll_count > cfg.move_interval);

	always_comb begin
		state_next = state;
		emit = 1'b0;
		report = '0;
		ax = state.acc_x;
		ay = state.acc_y;
		if (poll.link_configured) begin
			case (cfg.mode)
				db9h_pkg::MODE_GAME_PAD: begin
					ax = state.acc_x;
				end
				db9h_pkg::MODE_AMIGA: begin
					if (dir[3] && !old[3]) begin
						ax = state.acc_x + (dir[1] ? db9h_pkg::STEP_PLUS : db9h_pkg::STEP_MINUS);
					end
					if (dir[2] && !old[2]) begin
						ay = state.acc_y + (dir[0] ? db9h_pkg::STEP_PLUS : db9h_pkg::STEP_MINUS);
					end
					state_next.prev_dir_pins = dir;
				end
				db9h_pkg::MODE_PAD_MOUSE: begin
					if (tick) begin
						state_next.poll_count = '0;
						ax = state.acc_x + {7'd0, dir[3]} - {7'd0, dir[2]};
						ay = state.acc_y + {7'd0, dir[1]} - {7'd0, dir[0]};
					end else begin
						state_next.poll_count = state.poll_count + 16'd1;
					end
				end
				default: begin
					if (dir[0] && !old[0]) begin
						ax = state.acc_x + (dir[1] ? db9h_pkg::STEP_PLUS : db9h_pkg::STEP_MINUS);
					end
					if (dir[2] && !old[2]) begin
						ay = state.acc_y + (dir[3] ? db9h_pkg::STEP_PLUS : db9h_pkg::STEP_MINUS);
					end
					state_next.prev_dir_pins = dir;
				end
			endcase

			if (cfg.mode == db9h_pkg::MODE_GAME_PAD) begin
				if (game_btn != state.last_pad_buttons || hat != state.last_hat) begin
					emit = 1'b1;
					report.report_kind = db9h_pkg::KIND_GAME;
					report.hat_value = hat;
					report.button_bits = game_btn;
					if (ok) begin
						state_next.last_hat = hat;
						state_next.last_pad_buttons = game_btn;
					end
				end
			end else begin
				state_next.acc_x = ax;
				state_next.acc_y = ay;
				if (ax != 8'd0 || ay != 8'd0 || fire != state.last_mouse_buttons) begin
					emit = 1'b1;
					report.report_kind = db9h_pkg::KIND_MOUSE;
					report.button_bits = {5'd0, fire};
					report.move_x = ax;
					report.move_y = ay;
					if (ok) begin
						state_next.last_mouse_buttons = fire;
						state_next.acc_x = '0;
						state_next.acc_y = '0;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/db9_pad_to_hid_report_top.sv]
// Top level of the joystick-port poll to HID report converter.
//
//  channel   direction  handshake              payload
//  poll      in         in_valid / in_ready    in_data  (db9h_pkg::poll_t)
//  report    out        out_valid / out_ready  out_data (db9h_pkg::report_t)
//  config    in         cfg_we (no wait)       cfg_index, cfg_data
//
// Each poll beat is held in the input register and is evaluated from
// there into the report register, so one poll per cycle is sustained while the report side does not stall.
// The input register moves on whenever the report register is empty or is
// being emptied in the same cycle; a stalled report therefore holds back at
// most one poll, and in_ready drops only while both registers are full.
// Reset is asynchronous and active low; it clears the block state, the
// configuration (pad mode, no CD32 pad, interval 5000) and both valid flags.
`default_nettype none

`include "assert_macros.svh"

module db9_pad_to_hid_report_top (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  db9h_pkg::poll_t                       in_data,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output db9h_pkg::report_t                     out_data,
	input  wire                                   cfg_we,
	input  wire  [db9h_pkg::CfgIdxW-1:0]          cfg_index,
	input  wire  [db9h_pkg::CfgDataW-1:0]         cfg_data
);

	// Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
	db9h_pkg::cfg_t cfg_q;

	// Input register holding the poll under evaluation.
	logic            poll_valid_s1;
	db9h_pkg::poll_t poll_s1;

	// Block state carried from poll to poll.
	db9h_pkg::state_t state_q;
	db9h_pkg::state_t state_next;

	// Report register.
	logic              out_valid_q;
	db9h_pkg::report_t out_data_q;

	logic              emit;
	db9h_pkg::report_t report;
	logic              advance;

	// The poll in the input register is retired when there is room for its
	// report; a poll that yields no report is retired under the same rule.
	assign advance = poll_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !poll_valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= db9h_pkg::MODE_GAME_PAD;
			cfg_q.cd32_pad <= 1'b0;
			cfg_q.move_interval <= db9h_pkg::MOVE_INTERVAL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				db9h_pkg::REG_MODE: begin
					cfg_q.mode <= cfg_data[1:0];
				end
				db9h_pkg::REG_CD32_PAD: begin
					cfg_q.cd32_pad <= cfg_data[0];
				end
				db9h_pkg::REG_MOVE_INTERVAL: begin
					cfg_q.move_interval <= cfg_data;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			poll_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			poll_s1 <= in_data;
		end
	end

	db9h_core u_core (
		.cfg        (cfg_q),
		.state      (state_q),
		.poll       (poll_s1),
		.state_next (state_next),
		.emit       (emit),
		.report     (report)
	);

	// State follows each retired poll; the core leaves it untouched when the
	// link is not configured.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_data_q <= report;
		end
	end

	// A held poll is never dropped while the report side is stalled.
	`ASSERT_NEXT(a_poll_held, poll_valid_s1 && !advance, poll_valid_s1)
	// An accepted mouse report leaves both accumulators cleared.
	`ASSERT_NEXT(a_acc_cleared,
		advance && emit && poll_s1.report_accepted &&
		report.report_kind == db9h_pkg::KIND_MOUSE,
		state_q.acc_x == 8'd0 && state_q.acc_y == 8'd0)
	// A poll on an unconfigured link changes nothing.
	`ASSERT_NEXT(a_link_idle, advance && !poll_s1.link_configured, $stable(state_q))
	// A poll on an unconfigured link yields no report.
	`ASSERT_SAME(a_link_silent, advance && !poll_s1.link_configured, !emit)
	// A game report carries no movement.
	`ASSERT_SAME(a_game_still, out_valid_q && out_data_q.report_kind == db9h_pkg::KIND_GAME,
		out_data_q.move_x == 8'sd0 && out_data_q.move_y == 8'sd0)

endmodule

`default_nettype wire

[tb/sv/tb_db9_pad_to_hid_report_top.sv]
// Self-checking testbench of the joystick-port poll to HID report converter.
`timescale 1ns / 100ps

module tb_db9_pad_to_hid_report_top;
	import db9h_pkg::*;

	// Run shape. The cycle limit allows for the slowest legal run many times over:
	// every beat waiting out sender gaps and receiver stalls, plus the long hold-off.
	localparam int unsigned PHASES = 16;
	localparam int unsigned ITEMS_PER_PHASE = 64;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned CYCLE_LIMIT = 200000;

	// Our own view of the fixed tables and steps of the converter.
	localparam logic [3:0] HAT_OF_DIR [16] = '{
		4'd8, 4'd0, 4'd4, 4'd8, 4'd6, 4'd7, 4'd5, 4'd8,
		4'd2, 4'd1, 4'd3, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8
	};
	localparam logic [7:0] MOVE_UP = 8'd10;
	localparam logic [7:0] MOVE_DOWN = 8'd246;
	localparam logic [15:0] INTERVAL_AFTER_RESET = 16'd5000;

	// One line of the directed table: either a register write or a poll beat,
	// the latter optionally carrying a hand-written expectation.
	typedef struct {
		bit                  is_cfg;
		logic [CfgIdxW-1:0]  idx;
		logic [15:0]         val;
		poll_t               poll;
		bit                  typed;
		bit                  emits;
		report_t             rep;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	poll_t               in_data;
	logic                out_valid;
	logic                out_ready = 1'b0;
	report_t             out_data;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	// Shadow copy of the converter's state and registers, advanced once per
	// accepted poll beat.
	state_t      pad_state;
	cfg_t        pad_cfg;
	report_t     pending_reports [$];
	report_t     want;

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	bit          hold_req;
	bit          hold_done;
	int unsigned hold_left;
	int unsigned fail_count;
	int unsigned cycle_count;

	db9_pad_to_hid_report_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 12 ns period, six low and six high.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Works out the report, if any, that one poll causes, and moves the shadow
	// state on exactly as the converter should.
	function automatic bit next_hid_report(input poll_t p, output report_t r);
		logic [3:0] dir;
		logic [2:0] fire;
		logic [3:0] hat;
		logic [7:0] game_btn;
		dir = p.pin_levels[15:12];
		// Fire pins 9, 10 and 11 land on report bits 2, 1 and 0.
		fire = {p.pin_levels[9], p.pin_levels[10], p.pin_levels[11]};
		r = '0;
		// An unconfigured link leaves everything untouched.
		if (!p.link_configured)
			return 1'b0;
		case (pad_cfg.mode)
			MODE_GAME_PAD: begin
				hat = HAT_OF_DIR[dir];
				game_btn = pad_cfg.cd32_pad ? p.pad_buttons : {5'd0, fire};
				if (game_btn == pad_state.last_pad_buttons && hat == pad_state.last_hat)
					return 1'b0;
				r.report_kind = KIND_GAME;
				r.hat_value = hat;
				r.button_bits = game_btn;
				// A refused report leaves the history alone so that it is sent again.
				if (p.report_accepted) begin
					pad_state.last_hat = hat;
					pad_state.last_pad_buttons = game_btn;
				end
				return 1'b1;
			end
			MODE_AMIGA: begin
				if (dir[3] && !pad_state.prev_dir_pins[3])
					pad_state.acc_x = pad_state.acc_x + (dir[1] ? MOVE_UP : MOVE_DOWN);
				if (dir[2] && !pad_state.prev_dir_pins[2])
					pad_state.acc_y = pad_state.acc_y + (dir[0] ? MOVE_UP : MOVE_DOWN);
				pad_state.prev_dir_pins = dir;
			end
			MODE_PAD_MOUSE: begin
				if (pad_state.poll_count > pad_cfg.move_interval) begin
					pad_state.poll_count = '0;
					pad_state.acc_x = pad_state.acc_x + {7'd0, dir[3]} - {7'd0, dir[2]};
					pad_state.acc_y = pad_state.acc_y + {7'd0, dir[1]} - {7'd0, dir[0]};
				end else begin
					pad_state.poll_count = pad_state.poll_count + 16'd1;
				end
			end
			default: begin
				if (dir[0] && !pad_state.prev_dir_pins[0])
					pad_state.acc_x = pad_state.acc_x + (dir[1] ? MOVE_UP : MOVE_DOWN);
				if (dir[2] && !pad_state.prev_dir_pins[2])
					pad_state.acc_y = pad_state.acc_y + (dir[3] ? MOVE_UP : MOVE_DOWN);
				pad_state.prev_dir_pins = dir;
			end
		endcase
		// All mouse modes report while movement is pending or the buttons moved.
		if (pad_state.acc_x == '0 && pad_state.acc_y == '0 &&
		    fire == pad_state.last_mouse_buttons)
			return 1'b0;
		r.report_kind = KIND_MOUSE;
		r.button_bits = {5'd0, fire};
		r.move_x = pad_state.acc_x;
		r.move_y = pad_state.acc_y;
		if (p.report_accepted) begin
			pad_state.last_mouse_buttons = fire;
			pad_state.acc_x = '0;
			pad_state.acc_y = '0;
		end
		return 1'b1;
	endfunction

	function automatic stim_row_t poll_row(input logic [15:0] pins, input logic [7:0] pad,
	                                       input bit link, input bit acc);
		stim_row_t r;
		r.is_cfg = 1'b0;
		r.idx = '0;
		r.val = '0;
		r.poll = '{pin_levels: pins, pad_buttons: pad, link_configured: link,
		           report_accepted: acc};
		r.typed = 1'b0;
		r.emits = 1'b0;
		r.rep = '0;
		return r;
	endfunction

	function automatic stim_row_t typed_row(input logic [15:0] pins, input logic [7:0] pad,
	                                        input bit link, input bit acc, input bit emits,
	                                        input logic kind, input logic [3:0] hat,
	                                        input logic [7:0] btn, input logic [7:0] mx,
	                                        input logic [7:0] my);
		stim_row_t r;
		r = poll_row(pins, pad, link, acc);
		r.typed = 1'b1;
		r.emits = emits;
		r.rep = '{report_kind: kind, hat_value: hat, button_bits: btn, move_x: mx,
		          move_y: my};
		return r;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CfgIdxW-1:0] idx,
	                                      input logic [15:0] val);
		stim_row_t r;
		r = poll_row('0, '0, 1'b0, 1'b0);
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	// Random polls: a quarter repeat the previous pins so that the unchanged
	// case turns up often; the link is mostly up so that most beats do work.
	function automatic poll_t random_poll(input poll_t last);
		poll_t p;
		p = last;
		if ($urandom_range(99) >= 25) begin
			p.pin_levels = 16'($urandom);
			p.pad_buttons = 8'($urandom);
		end
		p.link_configured = ($urandom_range(99) < 90);
		p.report_accepted = ($urandom_range(99) < 70);
		return p;
	endfunction

	// Offers one poll beat, holding it until the block takes it, and queues the
	// report it should cause. Entered and left at a falling edge.
	task automatic send_poll(input poll_t p, input bit typed, input bit emits,
	                         input report_t rep);
		bit      hit;
		report_t r;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = p;
		do
			@(posedge clk);
		while (!in_ready);
		hit = next_hid_report(p, r);
		// Where the table spells the answer out, that answer is the one checked.
		if (typed) begin
			hit = emits;
			r = rep;
		end
		if (hit)
			pending_reports.push_back(r);
		@(negedge clk);
	endtask

	// Drops valid and lets the block drain. A poll that causes no report can still
	// sit in the input register once the last report is out, hence the extra cycles.
	task automatic settle_block();
		in_valid = 1'b0;
		while (pending_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_MODE:          pad_cfg.mode = val[1:0];
			REG_CD32_PAD:      pad_cfg.cd32_pad = val[0];
			REG_MOVE_INTERVAL: pad_cfg.move_interval = val;
			default:           ;
		endcase
	endtask

	// Receiver side: random stalls at the rate of the current phase, plus one
	// long hold-off, counted here, that lets the pipeline fill and push back.
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_left = HOLD_OFF_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left != 0) begin
			out_ready = 1'b0;
			hold_left = hold_left - 1;
		end else begin
			out_ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Every report beat is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				$error("report beat arrived with no report expected");
				fail_count++;
			end else begin
				want = pending_reports.pop_front();
				if (out_data.report_kind !== want.report_kind) begin
					$error("report_kind: expected %0d, got %0d", want.report_kind,
					       out_data.report_kind);
					fail_count++;
				end
				if (out_data.hat_value !== want.hat_value) begin
					$error("hat_value: expected %0d, got %0d", want.hat_value,
					       out_data.hat_value);
					fail_count++;
				end
				if (out_data.button_bits !== want.button_bits) begin
					$error("button_bits: expected %0d, got %0d", want.button_bits,
					       out_data.button_bits);
					fail_count++;
				end
				if (out_data.move_x !== want.move_x) begin
					$error("move_x: expected %0d, got %0d", want.move_x, out_data.move_x);
					fail_count++;
				end
				if (out_data.move_y !== want.move_y) begin
					$error("move_y: expected %0d, got %0d", want.move_y, out_data.move_y);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		stim_row_t directed_rows [$];
		poll_t     poll;
		int        counted;

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b0;
		hold_done = 1'b0;
		hold_left = 0;
		fail_count = 0;
		cycle_count = 0;
		pad_state = '0;
		pad_cfg = '{mode: MODE_GAME_PAD, cd32_pad: 1'b0, move_interval: INTERVAL_AFTER_RESET};
		poll = '0;

		// Game pad straight after reset: an ignored poll, the first report against
		// the cleared history, an unchanged poll, a refused report and its retry,
		// and the impossible all-directions pattern.
		directed_rows.push_back(typed_row(16'hFFFF, 8'hFF, 1'b0, 1'b1, 1'b0,
		                                  KIND_GAME, 4'd0, 8'h00, 8'h00, 8'h00));
		directed_rows.push_back(typed_row(16'h0000, 8'h00, 1'b1, 1'b1, 1'b1,
		                                  KIND_GAME, 4'd8, 8'h00, 8'h00, 8'h00));
		directed_rows.push_back(typed_row(16'h0000, 8'h00, 1'b1, 1'b1, 1'b0,
		                                  KIND_GAME, 4'd0, 8'h00, 8'h00, 8'h00));
		directed_rows.push_back(typed_row(16'h1E00, 8'h00, 1'b1, 1'b0, 1'b1,
		                                  KIND_GAME, 4'd0, 8'h07, 8'h00, 8'h00));
		directed_rows.push_back(typed_row(16'h1E00, 8'h00, 1'b1, 1'b1, 1'b1,
		                                  KIND_GAME, 4'd0, 8'h07, 8'h00, 8'h00));
		directed_rows.push_back(typed_row(16'hF000, 8'h00, 1'b1, 1'b1, 1'b1,
		                                  KIND_GAME, 4'd8, 8'h00, 8'h00, 8'h00));
		// Walk the hat round seven of its eight directions, then an opposed pair.
		directed_rows.push_back(poll_row(16'h8000, 8'h00, 1'b1, 1'b1));
		directed_rows.push_back(poll_row(16'hA000, 8'h00, 1'b1, 1'b1));
		directed_rows.push_back(poll_row(16'h2000, 8'h00, 1'b1, 1'b1));
		directed_rows.push_back(poll_row(16'h6000, 8'h00, 1'b1, 1'b1));
		directed_rows.push_back(poll_row(16'h4000, 8'h00, 1'b1, 1'b1));
		directed_rows.push_back(poll_row(16'h5000, 8'h00, 1'b1, 1'b1));
		directed_rows.push_back(poll_row(16'h9000, 8'h00, 1'b1, 1'b1));
		directed_rows.push_back(poll_row(16'h3000, 8'h00, 1'b1, 1'b1));
		// Buttons from the serial pad, at full scale and then a mixed pattern.
		directed_rows.push_back(cfg_row(REG_CD32_PAD, 16'd1));
		directed_rows.push_back(typed_row(16'h0000, 8'hFF, 1'b1, 1'b1, 1'b1,
		                                  KIND_GAME, 4'd8, 8'hFF, 8'h00, 8'h00));
		directed_rows.push_back(poll_row(16'h0E00, 8'h5A, 1'b1, 1'b1));
		// Amiga mouse: the edge history is still clear, so the first rising edge
		// on pin 15 with pin 13 high steps x by plus ten.
		directed_rows.push_back(cfg_row(REG_CD32_PAD, 16'd0));
		directed_rows.push_back(cfg_row(REG_MODE, 16'(MODE_AMIGA)));
		directed_rows.push_back(typed_row(16'hA000, 8'h00, 1'b1, 1'b1, 1'b1,
		                                  KIND_MOUSE, 4'd0, 8'h00, 8'd10, 8'h00));
		directed_rows.push_back(poll_row(16'h4000, 8'h00, 1'b1, 1'b0));
		directed_rows.push_back(poll_row(16'h0000, 8'h00, 1'b1, 1'b1));
		directed_rows.push_back(poll_row(16'h0E00, 8'h00, 1'b1, 1'b1));
		// Atari mouse keeps the history built up in Amiga mode.
		directed_rows.push_back(cfg_row(REG_MODE, 16'(MODE_ATARI)));
		directed_rows.push_back(poll_row(16'hF000, 8'h00, 1'b1, 1'b1));
		directed_rows.push_back(poll_row(16'h5000, 8'h00, 1'b1, 1'b1));
		// Pad as mouse with the shortest interval: a step every other poll.
		directed_rows.push_back(cfg_row(REG_MOVE_INTERVAL, 16'd0));
		directed_rows.push_back(cfg_row(REG_MODE, 16'(MODE_PAD_MOUSE)));
		directed_rows.push_back(poll_row(16'h9000, 8'h00, 1'b1, 1'b1));
		directed_rows.push_back(poll_row(16'h9000, 8'h00, 1'b1, 1'b1));
		directed_rows.push_back(poll_row(16'h9000, 8'h00, 1'b1, 1'b1));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				settle_block();
				write_reg(directed_rows[i].idx, directed_rows[i].val);
			end else begin
				send_poll(directed_rows[i].poll, directed_rows[i].typed,
				          directed_rows[i].emits, directed_rows[i].rep);
			end
		end

		// Random phases: every mode under every idling pattern, state carried
		// across mode changes. One pad-as-mouse phase uses the longest interval.
		for (int ph = 0; ph < PHASES; ph++) begin
			settle_block();
			write_reg(REG_MODE, 16'(ph % 4));
			write_reg(REG_CD32_PAD, 16'($urandom_range(1)));
			write_reg(REG_MOVE_INTERVAL, (ph == 6) ? 16'hFFFF : 16'($urandom_range(6)));
			case ((ph / 4) % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 67;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 67;
				end
				default: begin
					send_idle_pct = 37;
					recv_stall_pct = 37;
				end
			endcase
			// Back-pressure phase: the sender keeps offering with no gaps while the
			// receiver sits out a long stretch.
			if (ph == 1)
				hold_req = 1'b1;
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				poll = random_poll(poll);
				if (poll.link_configured)
					counted++;
				send_poll(poll, 1'b0, 1'b0, '0);
			end
		end

		settle_block();
		if (fail_count == 0 && pending_reports.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
